@@ rtl/ptdt_pkg.sv @@
package ptdt_pkg;

  // Fixed widths of the interface fields.
  localparam int unsigned TIME_W   = 16;
  localparam int unsigned EXEC_W   = 17;
  localparam int unsigned WIDE_W   = 32;
  localparam int unsigned NRT_W    = 33;
  localparam int unsigned ADDR_W   = 4;
  localparam int unsigned DATA_W   = 32;

  // Default width of the time registers.
  localparam int unsigned TIME_BITS_DEF = 16;

  typedef enum logic [1:0] {
    REG_WCET         = 2'd0,
    REG_REL_DEADLINE = 2'd1,
    REG_PERIOD       = 2'd2,
    REG_OFFSET       = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE      = 2'd0,
    ST_RUNNING   = 2'd1,
    ST_COMPLETED = 2'd2
  } status_e;

  // Configuration as seen by the datapath, zero-extended to the field width.
  typedef struct packed {
    logic [TIME_W-1:0] wcet;
    logic [TIME_W-1:0] rel_deadline;
    logic [TIME_W-1:0] period;
    logic [TIME_W-1:0] offset;
  } cfg_t;

  // Task state and per-beat flags handed from the step stage to the result stage.
  typedef struct packed {
    status_e                  status;
    logic signed [EXEC_W-1:0] exec_left;
    logic signed [WIDE_W-1:0] deadline_left;
    logic [TIME_W-1:0]        job_count;
    logic                     released;
    logic                     overrun;
    logic                     miss;
  } view_t;

endpackage

@@ rtl/ptdt_cfg.sv @@
module ptdt_cfg #(
  parameter int unsigned TIME_BITS = ptdt_pkg::TIME_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ptdt_pkg::ADDR_W-1:0] paddr,
  input  logic [ptdt_pkg::DATA_W-1:0] pwdata,
  output logic [ptdt_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output ptdt_pkg::cfg_t              cfg_o
);
  import ptdt_pkg::*;

  // Registers keep only the low bits that the time width allows.
  localparam int unsigned CFG_W = (TIME_BITS < TIME_W) ? TIME_BITS : TIME_W;

  logic [CFG_W-1:0] wcet_q, rel_deadline_q, period_q, offset_q;
  logic             wr_en;
  reg_idx_e         idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_e'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wcet_q         <= CFG_W'(1);
      rel_deadline_q <= CFG_W'(1);
      period_q       <= CFG_W'(1);
      offset_q       <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_WCET:         wcet_q         <= pwdata[CFG_W-1:0];
        REG_REL_DEADLINE: rel_deadline_q <= pwdata[CFG_W-1:0];
        REG_PERIOD:       period_q       <= pwdata[CFG_W-1:0];
        REG_OFFSET:       offset_q       <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_WCET:         prdata = DATA_W'(wcet_q);
      REG_REL_DEADLINE: prdata = DATA_W'(rel_deadline_q);
      REG_PERIOD:       prdata = DATA_W'(period_q);
      REG_OFFSET:       prdata = DATA_W'(offset_q);
      default:          prdata = '0;
    endcase
  end

  assign cfg_o.wcet         = TIME_W'(wcet_q);
  assign cfg_o.rel_deadline = TIME_W'(rel_deadline_q);
  assign cfg_o.period       = TIME_W'(period_q);
  assign cfg_o.offset       = TIME_W'(offset_q);

endmodule

@@ rtl/ptdt_step.sv @@
module ptdt_step #(
  parameter int unsigned TIME_BITS = ptdt_pkg::TIME_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ptdt_pkg::cfg_t              cfg_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        mode_i,
  input  logic                        dispatched_i,
  input  logic [ptdt_pkg::TIME_W-1:0] elapsed_i,
  input  logic                        s2_ready_i,
  output logic                        s1_valid_o,
  output ptdt_pkg::view_t             view_o
);
  import ptdt_pkg::*;

  localparam int unsigned DT_W = (TIME_BITS < TIME_W) ? TIME_BITS : TIME_W;
  localparam logic [TIME_W-1:0] DT_MASK = TIME_W'((33'd1 << DT_W) - 33'd1);

  status_e                  status_q, status_d;
  logic signed [EXEC_W-1:0] exec_q, exec_d;
  logic signed [WIDE_W-1:0] dl_q, dl_d;
  logic [WIDE_W-1:0]        total_q, total_d;
  logic [NRT_W-1:0]         nrt_q, nrt_d;
  logic [TIME_W-1:0]        count_q, count_d;
  logic                     rel_q, rel_d, ovr_q, ovr_d, miss_q, miss_d;
  logic                     v1_q;

  logic                     accept;
  logic [TIME_W-1:0]        dt;
  logic signed [EXEC_W:0]   ex_diff;
  logic signed [EXEC_W-1:0] ex_sat;
  logic [WIDE_W:0]          dl_diff;
  logic signed [WIDE_W-1:0] dl_sat;
  logic [WIDE_W:0]          tot_sum;
  logic [WIDE_W-1:0]        tot_sat;
  logic [NRT_W:0]           nrt_sum;
  logic [NRT_W-1:0]         nrt_sat;

  assign in_ready_o = !v1_q || s2_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign s1_valid_o = v1_q;

  assign dt = elapsed_i & DT_MASK;

  // Saturating arithmetic: a sign disagreement in the top two bits means underflow.
  assign ex_diff = {exec_q[EXEC_W-1], exec_q} - $signed({2'b00, dt});
  assign ex_sat  = (ex_diff[EXEC_W] != ex_diff[EXEC_W-1]) ? {1'b1, {(EXEC_W-1){1'b0}}}
                                                          : ex_diff[EXEC_W-1:0];
  assign dl_diff = {dl_q[WIDE_W-1], dl_q} - {{(WIDE_W-TIME_W+1){1'b0}}, dt};
  assign dl_sat  = (dl_diff[WIDE_W] != dl_diff[WIDE_W-1]) ? {1'b1, {(WIDE_W-1){1'b0}}}
                                                          : dl_diff[WIDE_W-1:0];
  assign tot_sum = {1'b0, total_q} + {{(WIDE_W-TIME_W+1){1'b0}}, dt};
  assign tot_sat = tot_sum[WIDE_W] ? '1 : tot_sum[WIDE_W-1:0];
  assign nrt_sum = {1'b0, nrt_q} + {{(NRT_W-TIME_W+1){1'b0}}, cfg_i.period};
  assign nrt_sat = nrt_sum[NRT_W] ? '1 : nrt_sum[NRT_W-1:0];

  always_comb begin
    status_d = status_q;
    exec_d   = exec_q;
    dl_d     = dl_q;
    total_d  = total_q;
    nrt_d    = nrt_q;
    count_d  = count_q;
    rel_d    = 1'b0;
    ovr_d    = 1'b0;
    miss_d   = 1'b0;
    if (mode_i) begin
      status_d = ST_IDLE;
      exec_d   = $signed({1'b0, cfg_i.wcet});
      dl_d     = $signed({{(WIDE_W-TIME_W){1'b0}}, cfg_i.rel_deadline});
      total_d  = '0;
      count_d  = TIME_W'(1);
      nrt_d    = {{(NRT_W-TIME_W){1'b0}}, cfg_i.offset}
               + {{(NRT_W-TIME_W){1'b0}}, cfg_i.period};
    end else if (dispatched_i && status_q == ST_COMPLETED) begin
      ovr_d = 1'b1;
    end else begin
      if (!dispatched_i) begin
        if (status_q == ST_RUNNING) begin
          status_d = ST_IDLE;
        end
      end else begin
        exec_d   = ex_sat;
        status_d = (!ex_sat[EXEC_W-1] && ex_sat != '0) ? ST_RUNNING : ST_COMPLETED;
      end
      total_d = tot_sat;
      dl_d    = dl_sat;
      if (dl_d < $signed({{(WIDE_W-EXEC_W){exec_d[EXEC_W-1]}}, exec_d})) begin
        miss_d = 1'b1;
      end else if ({1'b0, total_d} >= nrt_q) begin
        rel_d    = 1'b1;
        count_d  = (count_q != '1) ? count_q + TIME_W'(1) : count_q;
        nrt_d    = nrt_sat;
        status_d = ST_IDLE;
        exec_d   = $signed({1'b0, cfg_i.wcet});
        dl_d     = $signed({{(WIDE_W-TIME_W){1'b0}}, cfg_i.rel_deadline});
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q <= ST_IDLE;
      exec_q   <= EXEC_W'(1);
      dl_q     <= WIDE_W'(1);
      total_q  <= '0;
      nrt_q    <= NRT_W'(1);
      count_q  <= TIME_W'(1);
      rel_q    <= 1'b0;
      ovr_q    <= 1'b0;
      miss_q   <= 1'b0;
      v1_q     <= 1'b0;
    end else begin
      if (accept) begin
        status_q <= status_d;
        exec_q   <= exec_d;
        dl_q     <= dl_d;
        total_q  <= total_d;
        nrt_q    <= nrt_d;
        count_q  <= count_d;
        rel_q    <= rel_d;
        ovr_q    <= ovr_d;
        miss_q   <= miss_d;
        v1_q     <= 1'b1;
      end else if (s2_ready_i) begin
        v1_q <= 1'b0;
      end
    end
  end

  assign view_o.status        = status_q;
  assign view_o.exec_left     = exec_q;
  assign view_o.deadline_left = dl_q;
  assign view_o.job_count     = count_q;
  assign view_o.released      = rel_q;
  assign view_o.overrun       = ovr_q;
  assign view_o.miss          = miss_q;

`ifndef SYNTHESIS
  a_ovr_completed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && ovr_q) |-> (status_q == ST_COMPLETED && !rel_q && !miss_q))
    else $error("overrun beat without a completed task");

  a_rel_reload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && rel_q) |-> (status_q == ST_IDLE && exec_q == $signed({1'b0, cfg_i.wcet})))
    else $error("release did not reload the job");

  a_nrt_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(accept && mode_i) |=> (nrt_q >= $past(nrt_q)))
    else $error("release point moved backwards without a restart");
`endif

endmodule

@@ rtl/ptdt_result.sv @@
module ptdt_result (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  ptdt_pkg::view_t                    view_i,
  input  logic [ptdt_pkg::TIME_W-1:0]        rel_deadline_i,
  input  logic                               s1_valid_i,
  output logic                               s2_ready_o,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [1:0]                         status_o,
  output logic signed [ptdt_pkg::EXEC_W-1:0] remaining_exec_o,
  output logic signed [ptdt_pkg::WIDE_W-1:0] time_to_deadline_o,
  output logic signed [ptdt_pkg::WIDE_W-1:0] laxity_o,
  output logic signed [ptdt_pkg::WIDE_W-1:0] response_o,
  output logic [ptdt_pkg::TIME_W-1:0]        release_count_o,
  output logic                               released_o,
  output logic                               overrun_o,
  output logic                               deadline_miss_o,
  output logic                               is_ready_o
);
  import ptdt_pkg::*;

  logic                     out_valid_q;
  logic                     load;
  logic [WIDE_W:0]          lax_diff, resp_diff;
  logic signed [WIDE_W-1:0] lax, resp;

  assign s2_ready_o  = !out_valid_q || out_ready_i;
  assign load        = s1_valid_i && s2_ready_o;
  assign out_valid_o = out_valid_q;

  assign lax_diff = {view_i.deadline_left[WIDE_W-1], view_i.deadline_left}
                  - {{(WIDE_W-EXEC_W+1){view_i.exec_left[EXEC_W-1]}}, view_i.exec_left};
  assign lax = (lax_diff[WIDE_W] != lax_diff[WIDE_W-1])
             ? (lax_diff[WIDE_W] ? {1'b1, {(WIDE_W-1){1'b0}}} : {1'b0, {(WIDE_W-1){1'b1}}})
             : lax_diff[WIDE_W-1:0];

  assign resp_diff = {{(WIDE_W-TIME_W+1){1'b0}}, rel_deadline_i} - {lax[WIDE_W-1], lax};
  assign resp = (resp_diff[WIDE_W] != resp_diff[WIDE_W-1])
              ? (resp_diff[WIDE_W] ? {1'b1, {(WIDE_W-1){1'b0}}} : {1'b0, {(WIDE_W-1){1'b1}}})
              : resp_diff[WIDE_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      status_o           <= view_i.status;
      remaining_exec_o   <= view_i.exec_left;
      time_to_deadline_o <= view_i.deadline_left;
      laxity_o           <= lax;
      response_o         <= resp;
      release_count_o    <= view_i.job_count;
      released_o         <= view_i.released;
      overrun_o          <= view_i.overrun;
      deadline_miss_o    <= view_i.miss;
      is_ready_o         <= (view_i.status == ST_IDLE) || (view_i.status == ST_RUNNING);
    end
  end

`ifndef SYNTHESIS
  a_miss_negative: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && deadline_miss_o) |-> laxity_o[WIDE_W-1])
    else $error("deadline miss reported with non-negative laxity");

  a_release_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && released_o) |-> (is_ready_o && !deadline_miss_o && !overrun_o))
    else $error("release beat carries a conflicting flag");
`endif

endmodule

@@ rtl/periodic_task_deadline_tracker.sv @@
// Channel  | Handshake               | Payload
// ---------+-------------------------+------------------------------------------------
// input    | in_valid_i / in_ready_o | mode_i, dispatched_i, elapsed_i
// result   | out_valid_o/out_ready_i | status_o, remaining_exec_o, time_to_deadline_o,
//          |                         | laxity_o, response_o, release_count_o,
//          |                         | released_o, overrun_o, deadline_miss_o, is_ready_o
// config   | psel, penable, pwrite   | paddr, pwdata, prdata, pready (always high)
//
// Every input beat yields exactly one result beat, via the step and result stages.
// One beat is accepted per cycle while in_ready_o is high; the state loops on itself.
// A stalled result holds in the output register while one further beat waits in the
// step stage; only then does in_ready_o fall.
// Reset (rst_ni low, asynchronous) loads the register defaults and the task state.
module periodic_task_deadline_tracker #(
  parameter int unsigned TIME_BITS = ptdt_pkg::TIME_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration port.
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [ptdt_pkg::ADDR_W-1:0]        paddr,
  input  logic [ptdt_pkg::DATA_W-1:0]        pwdata,
  output logic [ptdt_pkg::DATA_W-1:0]        prdata,
  output logic                               pready,
  // Input channel.
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               mode_i,
  input  logic                               dispatched_i,
  input  logic [ptdt_pkg::TIME_W-1:0]        elapsed_i,
  // Result channel.
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [1:0]                         status_o,
  output logic signed [ptdt_pkg::EXEC_W-1:0] remaining_exec_o,
  output logic signed [ptdt_pkg::WIDE_W-1:0] time_to_deadline_o,
  output logic signed [ptdt_pkg::WIDE_W-1:0] laxity_o,
  output logic signed [ptdt_pkg::WIDE_W-1:0] response_o,
  output logic [ptdt_pkg::TIME_W-1:0]        release_count_o,
  output logic                               released_o,
  output logic                               overrun_o,
  output logic                               deadline_miss_o,
  output logic                               is_ready_o
);
  import ptdt_pkg::*;

  // The offset only takes effect at the next restart, as the step stage copies the
  // configuration into the task state then; the budget, the period and the
  // relative deadline are also read directly on each release, and the relative
  // deadline on each result.
  cfg_t  cfg;
  view_t view;
  logic  s1_valid;
  logic  s2_ready;

  ptdt_cfg #(
    .TIME_BITS(TIME_BITS)
  ) u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  // Step stage: the task state itself is the stage register, so the next beat may
  // be applied in the cycle after this one while its result moves on.
  ptdt_step #(
    .TIME_BITS(TIME_BITS)
  ) u_step (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .mode_i      (mode_i),
    .dispatched_i(dispatched_i),
    .elapsed_i   (elapsed_i),
    .s2_ready_i  (s2_ready),
    .s1_valid_o  (s1_valid),
    .view_o      (view)
  );

  // Result stage: laxity is derived from the stored state and response from laxity and
  // the configured relative deadline; both are registered with the rest of the beat.
  ptdt_result u_result (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .view_i            (view),
    .rel_deadline_i    (cfg.rel_deadline),
    .s1_valid_i        (s1_valid),
    .s2_ready_o        (s2_ready),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .status_o          (status_o),
    .remaining_exec_o  (remaining_exec_o),
    .time_to_deadline_o(time_to_deadline_o),
    .laxity_o          (laxity_o),
    .response_o        (response_o),
    .release_count_o   (release_count_o),
    .released_o        (released_o),
    .overrun_o         (overrun_o),
    .deadline_miss_o   (deadline_miss_o),
    .is_ready_o        (is_ready_o)
  );

endmodule
